### rtl/cbm2_pkg.sv
// ----------------------------------------------------------------------------
// cbm2_pkg: shared types and constants of the cartridge bank mapper
// Transaction payloads, result kinds and reset values used by the decoder and the core.
// ----------------------------------------------------------------------------
package cbm2_pkg;

	localparam int RAM_CELLS_DEF = 512;
	localparam int BANK_BITS_DEF = 8;

	localparam logic [7:0] MASK_RESET = 8'h0F;
	localparam logic [7:0] BANK_RESET = 8'h01;
	localparam logic [7:0] OPEN_BUS   = 8'hFF;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [1:0] {
		KIND_ROM   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_WROTE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic        opcode;
		logic [15:0] bus_address;
		logic [7:0]  write_byte;
	} in_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [21:0] rom_address;
		logic [7:0]  read_byte;
	} out_t;

	typedef struct packed {
		kind_t       kind;
		logic [21:0] rom_address;
		logic [7:0]  read_byte;
		logic        ram_rd;
		logic        ram_we;
		logic        bank_we;
		logic [7:0]  bank_val;
	} dec_t;

endpackage

### rtl/cbm2_ram.sv
// ----------------------------------------------------------------------------
// cbm2_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cbm2_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/cbm2_decode.sv
// ----------------------------------------------------------------------------
// cbm2_decode: address decoder of the bank mapper
// Classifies one bus transaction and forms the ROM address, RAM index and
// the register and RAM write controls.
// ----------------------------------------------------------------------------
module cbm2_decode #(
	parameter int RAM_CELLS = cbm2_pkg::RAM_CELLS_DEF,
	parameter int BANK_BITS = cbm2_pkg::BANK_BITS_DEF
) (
	input  cbm2_pkg::in_t                item,
	input  logic [7:0]                   bank,
	input  logic [7:0]                   mask,
	output cbm2_pkg::dec_t               dec,
	output logic [$clog2(RAM_CELLS)-1:0] ram_idx
);

	localparam int IDX_W = $clog2(RAM_CELLS);

	function automatic logic [IDX_W-1:0] cell_index(input logic [8:0] v);
		logic [16:0] r;
		r = 17'(v);
		for (int k = 4; k >= 0; k--) begin
			if (r >= (17'(RAM_CELLS) << k)) begin
				r = r - (17'(RAM_CELLS) << k);
			end
		end
		return r[IDX_W-1:0];
	endfunction

	logic [15:0]          addr;
	logic                 area_rom0;
	logic                 area_romn;
	logic                 area_ram;
	logic                 area_open;
	logic                 area_bank;
	logic [BANK_BITS-1:0] sel_bank;

	assign addr      = item.bus_address;
	assign area_rom0 = (addr[15:14] == 2'b00);
	assign area_romn = (addr[15:14] == 2'b01);
	assign area_ram  = (addr[15:9] == 7'b1010000);
	assign area_open = (addr[15:13] == 3'b101) && !area_ram;
	assign area_bank = (addr[15:13] == 3'b001);
	assign sel_bank  = BANK_BITS'(bank & mask);
	assign ram_idx   = cell_index(addr[8:0]);

	always_comb begin
		dec             = '0;
		dec.kind        = cbm2_pkg::KIND_NONE;
		dec.bank_val    = (item.write_byte == 8'h00) ? cbm2_pkg::BANK_RESET : item.write_byte;
		if (item.opcode == cbm2_pkg::OP_READ) begin
			priority if (area_rom0) begin
				dec.kind        = cbm2_pkg::KIND_ROM;
				dec.rom_address = 22'(addr[13:0]);
			end else if (area_romn) begin
				dec.kind        = cbm2_pkg::KIND_ROM;
				dec.rom_address = 22'({sel_bank, addr[13:0]});
			end else if (area_ram) begin
				dec.kind   = cbm2_pkg::KIND_DATA;
				dec.ram_rd = 1'b1;
			end else if (area_open) begin
				dec.kind      = cbm2_pkg::KIND_DATA;
				dec.read_byte = cbm2_pkg::OPEN_BUS;
			end else begin
				dec.kind = cbm2_pkg::KIND_NONE;
			end
		end else begin
			priority if (!addr[15]) begin
				dec.kind    = cbm2_pkg::KIND_WROTE;
				dec.bank_we = area_bank;
			end else if (area_ram) begin
				dec.kind   = cbm2_pkg::KIND_WROTE;
				dec.ram_we = 1'b1;
			end else if (area_open) begin
				dec.kind = cbm2_pkg::KIND_WROTE;
			end else begin
				dec.kind = cbm2_pkg::KIND_NONE;
			end
		end
	end

endmodule

### rtl/cartridge_bank_mapper_mbc2_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_mbc2_core: ROM bank mapper with built-in nibble RAM
// Each transaction passes the input register, then the result register.
// The input register feeds the decoder, the RAM read and the result register.
// One transaction per cycle unless stalled. After reset the nibble RAM is
// cleared one cell per cycle, accepting nothing; bank resets to 1, mask 15.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_mbc2_core #(
	parameter int RAM_CELLS = cbm2_pkg::RAM_CELLS_DEF,
	parameter int BANK_BITS = cbm2_pkg::BANK_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  cbm2_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output cbm2_pkg::out_t out_data,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(RAM_CELLS);

	cbm2_pkg::in_t   item_s1;
	logic            valid_s1;
	logic            valid_s2;
	cbm2_pkg::kind_t kind_s2;
	logic [21:0]     rom_s2;
	logic [7:0]      byte_s2;
	logic            ram_sel_s2;
	logic [7:0]      bank_q;
	logic [7:0]      mask_q;
	logic [IDX_W-1:0] clr_q;
	logic            clearing_q;

	cbm2_pkg::dec_t   dec;
	logic [IDX_W-1:0] ram_idx;
	logic [3:0]       ram_rdata;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [3:0]       ram_wdata;
	logic             s2_free;
	logic             advance;
	logic             accept;

	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = clearing_q || (valid_s1 && !s2_free);
	assign accept   = in_valid && !in_stall;

	cbm2_decode #(
		.RAM_CELLS(RAM_CELLS),
		.BANK_BITS(BANK_BITS)
	) u_decode (
		.item   (item_s1),
		.bank   (bank_q),
		.mask   (mask_q),
		.dec    (dec),
		.ram_idx(ram_idx)
	);

	assign ram_we    = clearing_q || (advance && dec.ram_we);
	assign ram_waddr = clearing_q ? clr_q : ram_idx;
	assign ram_wdata = clearing_q ? 4'h0 : item_s1.write_byte[3:0];

	cbm2_ram #(
		.WIDTH(4),
		.DEPTH(RAM_CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (advance && dec.ram_rd),
		.raddr(ram_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			bank_q     <= cbm2_pkg::BANK_RESET;
			mask_q     <= cbm2_pkg::MASK_RESET;
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else begin
			if (clearing_q) begin
				clr_q <= clr_q + 1'b1;
				if (clr_q == IDX_W'(RAM_CELLS - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			if (cfg_we) begin
				mask_q <= cfg_wdata;
			end
			if (advance && dec.bank_we) begin
				bank_q <= dec.bank_val;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (s2_free) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			kind_s2    <= dec.kind;
			rom_s2     <= dec.rom_address;
			byte_s2    <= dec.read_byte;
			ram_sel_s2 <= dec.ram_rd;
		end
	end

	assign out_valid             = valid_s2;
	assign out_data.result_kind  = kind_s2;
	assign out_data.rom_address  = rom_s2;
	assign out_data.read_byte    = ram_sel_s2 ? {4'h0, ram_rdata} : byte_s2;

endmodule
